@@ rtl/core/ult_pkg.sv @@
package ult_pkg;

    typedef enum logic [2:0] {
        K_CLEAR  = 3'd0,
        K_APPEND = 3'd1,
        K_LOOKUP = 3'd2,
        K_DELETE = 3'd3,
        K_REWIND = 3'd4,
        K_READ   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_PAST = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
    } req_word_t;

    typedef struct packed {
        logic               found;
        logic signed [31:0] item;
        logic [7:0]         count;
        logic [1:0]         status;
    } rsp_word_t;

endpackage

@@ rtl/core/unordered_list_table_unit.sv @@
// channel | valid     | stall     | word
// --------+-----------+-----------+------------------------------------
// request | req_valid | req_stall | req (kind, value)
// result  | rsp_valid | rsp_stall | rsp (found, item, count, status)
//
// Clear, append, rewind and unused kinds are answered from the idle state. Read
// next goes through S_RDN for the registered RAM read. Lookup and delete compare
// one entry per cycle in S_SCAN, moved-in entries included (S_MOVE); the
// single-read-port entry RAM sets this.
// Reset empties the table and zeroes the read cursor; no clearing pass.
// A stalled result waits in the output register; a second waits internally.
module unordered_list_table_unit
    import ult_pkg::*;
#(
    parameter int CAPACITY   = 128,
    parameter int VALUE_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                  out_free;
    logic                  push;
    rsp_word_t             res;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;

    logic      rsp_valid_reg, rsp_valid_next;
    rsp_word_t rsp_reg, rsp_next;

    ult_ctrl #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .out_free  (out_free),
        .push      (push),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ult_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_BITS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (push)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/core/ult_ram.sv @@
module ult_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int AW    = 7
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/ult_ctrl.sv @@
module ult_ctrl
    import ult_pkg::*;
#(
    parameter int CAPACITY   = 128,
    parameter int VALUE_BITS = 32,
    parameter int AW         = 7,
    parameter int CW         = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  req_word_t             req,
    output logic                  req_stall,
    input  logic                  out_free,
    output logic                  push,
    output rsp_word_t             res,
    output logic                  mem_we,
    output logic [AW-1:0]         mem_waddr,
    output logic [VALUE_BITS-1:0] mem_wdata,
    output logic [AW-1:0]         mem_raddr,
    input  logic [VALUE_BITS-1:0] mem_rdata
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_MOVE = 5'b00100,
        S_RDN  = 5'b01000,
        S_WAIT = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic [CW-1:0]         cursor_reg, cursor_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  del_reg, del_next;
    rsp_word_t             res_reg, res_next;

    logic [63:0]           val_wide;
    logic [VALUE_BITS-1:0] val_in;
    logic [63:0]           rd_wide;
    logic [CW+7:0]         fill_wide;
    logic [CW-1:0]         idx_inc, fill_dec;
    logic                  hit;
    logic                  done;
    logic                  found_c;
    logic [31:0]           item_c;
    status_t               status_c;
    rsp_word_t             r;

    assign val_wide  = {32'd0, req.value};
    assign val_in    = val_wide[VALUE_BITS-1:0];
    assign rd_wide   = 64'(mem_rdata);
    assign idx_inc   = idx_reg + CW'(1);
    assign fill_dec  = fill_reg - CW'(1);
    assign hit       = (mem_rdata == val_reg);
    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        cursor_next = cursor_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        del_next    = del_reg;
        res_next    = res_reg;
        done        = 1'b0;
        push        = 1'b0;
        found_c     = 1'b0;
        item_c      = '0;
        status_c    = ST_OK;
        mem_we      = 1'b0;
        mem_waddr   = fill_reg[AW-1:0];
        mem_wdata   = val_in;
        mem_raddr   = idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req.kind)
                        K_CLEAR:
                        begin
                            fill_next = '0;
                            done      = 1'b1;
                        end
                        K_APPEND:
                        begin
                            if (fill_reg < CW'(CAPACITY))
                            begin
                                mem_we    = 1'b1;
                                fill_next = fill_reg + CW'(1);
                            end
                            else
                            begin
                                status_c = ST_FULL;
                            end
                            done = 1'b1;
                        end
                        K_LOOKUP, K_DELETE:
                        begin
                            val_next = val_in;
                            del_next = (req.kind == K_DELETE);
                            idx_next = '0;
                            if (fill_reg == '0)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                mem_raddr  = '0;
                                state_next = S_SCAN;
                            end
                        end
                        K_REWIND:
                        begin
                            cursor_next = '0;
                            done        = 1'b1;
                        end
                        K_READ:
                        begin
                            if (cursor_reg < fill_reg)
                            begin
                                mem_raddr  = cursor_reg[AW-1:0];
                                state_next = S_RDN;
                            end
                            else
                            begin
                                status_c = ST_PAST;
                                done     = 1'b1;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit && !del_reg)
                begin
                    found_c = 1'b1;
                    item_c  = rd_wide[31:0];
                    done    = 1'b1;
                end
                else if (hit)
                begin
                    fill_next = fill_dec;
                    if (idx_reg == fill_dec)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        mem_raddr  = fill_dec[AW-1:0];
                        state_next = S_MOVE;
                    end
                end
                else if (idx_inc >= fill_reg)
                begin
                    done = 1'b1;
                end
                else
                begin
                    mem_raddr = idx_inc[AW-1:0];
                    idx_next  = idx_inc;
                end
            end
            S_MOVE:
            begin
                // last entry fills the freed slot, then gets checked again
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = mem_rdata;
                if (hit)
                begin
                    fill_next = fill_dec;
                    if (idx_reg == fill_dec)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        mem_raddr = fill_dec[AW-1:0];
                    end
                end
                else if (idx_inc >= fill_reg)
                begin
                    done = 1'b1;
                end
                else
                begin
                    mem_raddr  = idx_inc[AW-1:0];
                    idx_next   = idx_inc;
                    state_next = S_SCAN;
                end
            end
            S_RDN:
            begin
                item_c      = rd_wide[31:0];
                cursor_next = cursor_reg + CW'(1);
                done        = 1'b1;
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        fill_wide = (CW+8)'(fill_next);
        r.found   = found_c;
        r.item    = item_c;
        r.count   = fill_wide[7:0];
        r.status  = status_c;

        if (done)
        begin
            if (out_free)
            begin
                push       = 1'b1;
                state_next = S_IDLE;
            end
            else
            begin
                res_next   = r;
                state_next = S_WAIT;
            end
        end

        res = done ? r : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            cursor_reg <= '0;
            idx_reg    <= '0;
            del_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            cursor_reg <= cursor_next;
            idx_reg    <= idx_next;
            del_reg    <= del_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        res_reg <= res_next;
    end

endmodule

@@ bench/tb.sv @@
module tb;
    import ult_pkg::*;

    localparam int CAPACITY = 128;
    localparam int TOTAL_REQS = 1350;
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;
    localparam int MAX_REPORTS = 40;

    class table_shadow;
        logic signed [31:0] slots [CAPACITY];
        int unsigned fill;
        int unsigned cursor;
        rsp_word_t owed [$];
        int unsigned errors;

        function new();
            fill = 0;
            cursor = 0;
            errors = 0;
        endfunction

        function void note_request(req_word_t w);
            rsp_word_t r;
            int unsigned i;
            r = '0;
            case (w.kind)
                K_CLEAR:
                    fill = 0;
                K_APPEND:
                    if (fill < CAPACITY)
                    begin
                        slots[fill] = w.value;
                        fill++;
                    end
                    else
                        r.status = ST_FULL;
                K_LOOKUP:
                    for (i = 0; i < fill && !r.found; i++)
                    begin
                        if (slots[i] == w.value)
                        begin
                            r.found = 1'b1;
                            r.item = slots[i];
                        end
                    end
                K_DELETE:
                begin
                    i = 0;
                    while (i < fill)
                    begin
                        if (slots[i] == w.value)
                        begin
                            fill--;
                            slots[i] = slots[fill];
                        end
                        else
                            i++;
                    end
                end
                K_REWIND:
                    cursor = 0;
                K_READ:
                    if (cursor < fill)
                    begin
                        r.item = slots[cursor];
                        cursor++;
                    end
                    else
                        r.status = ST_PAST;
                default:
                    ;
            endcase
            r.count = fill[7:0];
            owed.push_back(r);
        endfunction

        function void report(string name, longint exp_v, longint got_v);
            if (errors < MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        endfunction

        function void check_result(rsp_word_t got);
            rsp_word_t exp_w;
            if (owed.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $error("result word with none outstanding");
                errors++;
                return;
            end
            exp_w = owed.pop_front();
            if (got.found !== exp_w.found)
                report("found", exp_w.found, got.found);
            if (got.item !== exp_w.item)
                report("item", exp_w.item, got.item);
            if (got.count !== exp_w.count)
                report("count", exp_w.count, got.count);
            if (got.status !== exp_w.status)
                report("status", exp_w.status, got.status);
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp;

    table_shadow sb = new();
    bit calm = 1'b0;
    int unsigned sent = 0;
    logic signed [31:0] pool [6];

    unordered_list_table_unit #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (32)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    task automatic send(logic [2:0] kind, logic signed [31:0] value);
        req_word_t w;
        int unsigned gap;
        w.kind = kind;
        w.value = value;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        sb.note_request(w);
        sent++;
    endtask

    function automatic logic signed [31:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 3);
        if (r < 2)
            return pool[$urandom_range(0, 5)];
        if (r == 2 && sb.fill > 0)
            return sb.slots[$urandom_range(0, sb.fill - 1)];
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return K_APPEND;
        if (r < 50) return K_LOOKUP;
        if (r < 65) return K_DELETE;
        if (r < 85) return K_READ;
        if (r < 93) return K_REWIND;
        if (r < 97) return K_CLEAR;
        if (r < 98) return KIND_SPARE_A;
        if (r < 99) return KIND_SPARE_B;
        return K_APPEND;
    endfunction

    function automatic void new_pool();
        for (int k = 0; k < 6; k++)
        begin
            case ($urandom_range(0, 5))
                0: pool[k] = 32'sh8000_0000;
                1: pool[k] = 32'sh7fff_ffff;
                2: pool[k] = '0;
                3: pool[k] = -32'sd1;
                default: pool[k] = $urandom;
            endcase
        end
    endfunction

    // result side: draw a stall per word, then take the next word
    initial
    begin
        rsp_word_t got;
        int unsigned n;
        @(posedge clk iff rst_n);
        forever
        begin
            n = calm ? 0 : $urandom_range(0, 19);
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
            got = rsp;
            sb.check_result(got);
        end
    end

    initial
    begin
        int unsigned mode;
        bit first;
        first = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, duplicates, delete recheck, read past end, spare kinds
        send(K_APPEND, 32'sh7fff_ffff);
        send(K_APPEND, 32'sh8000_0000);
        send(K_APPEND, '0);
        send(K_APPEND, -32'sd1);
        send(K_APPEND, 32'sh5555_5555);
        send(K_APPEND, 32'shaaaa_aaaa);
        send(K_APPEND, 32'sh8000_0000);
        send(K_LOOKUP, 32'sh8000_0000);
        send(K_LOOKUP, 32'sd12345);
        send(K_REWIND, -32'sd1);
        send(K_READ, '0);
        send(K_READ, -32'sd1);
        send(K_DELETE, 32'sh8000_0000);
        send(K_READ, '0);
        send(K_READ, '0);
        send(K_READ, '0);
        send(K_READ, '0);
        send(KIND_SPARE_A, 32'sh1234_5678);
        send(KIND_SPARE_B, -32'sd1);
        send(K_CLEAR, 32'sh7fff_ffff);
        send(K_READ, '0);
        send(K_REWIND, '0);
        send(K_READ, '0);
        send(K_DELETE, '0);
        send(K_LOOKUP, -32'sd1);

        while (sent < TOTAL_REQS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            new_pool();
            mode = first ? 0 : $urandom_range(0, 4);
            first = 1'b0;
            case (mode)
                0:
                begin
                    while (sb.fill < CAPACITY)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send(K_LOOKUP, pick_value());
                        else
                            send(K_APPEND, pick_value());
                    end
                    repeat ($urandom_range(1, 4)) send(K_APPEND, pick_value());
                end
                1, 4:
                    repeat ($urandom_range(20, 60)) send(pick_kind(), pick_value());
                2:
                begin
                    send(K_REWIND, pick_value());
                    repeat (sb.fill + 2) send(K_READ, pick_value());
                end
                default:
                    repeat ($urandom_range(3, 12)) send(K_DELETE, pick_value());
            endcase
        end
        req_valid <= 1'b0;

        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
